// ===== src/lsmp_pkg.sv =====
// Package for the lidar scan-to-map point converter: shared types, register
// codes, CORDIC constants and small helper functions.
// Depends on nothing; every other file in src but lsmp_fifo uses it.
package lsmp_pkg;

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned ANG_W     = 16;
  localparam int unsigned RNG_W     = 16;
  localparam int unsigned MAP_W     = 24;
  localparam int unsigned IDX_CAP   = 4095;

  // CORDIC datapath widths: x and y in Q16 millimetres, z in 2^-32 turns.
  localparam int unsigned VEC_W     = 17;
  localparam int unsigned PROD_W    = 49;
  localparam int unsigned XW        = 36;
  localparam int unsigned ZW        = 33;
  localparam int unsigned RND_W     = 20;
  localparam int unsigned SUM_W     = 26;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned GAIN_SHIFT = 14;

  localparam logic [30:0] CORDIC_GAIN = 31'd652032874;
  localparam logic signed [XW-1:0] ROUND_HALF = XW'(32768);
  localparam logic signed [ANG_W:0] QUARTER_POS = 17'sd16384;
  localparam logic signed [ANG_W:0] QUARTER_NEG = -17'sd16384;
  localparam logic signed [ANG_W:0] HALF_TURN = 17'sd32768;
  localparam logic signed [SUM_W-1:0] MAP_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] MAP_MIN = -SUM_W'(8388608);

  typedef enum logic [2:0] {
    REG_RANGE_MIN    = 3'd0,
    REG_RANGE_MAX    = 3'd1,
    REG_ANGLE_START  = 3'd2,
    REG_ANGLE_STEP   = 3'd3,
    REG_POSE_X       = 3'd4,
    REG_POSE_Y       = 3'd5,
    REG_POSE_HEADING = 3'd6,
    REG_LASER_OFS_X  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [RNG_W-1:0] range_mm;
    logic             scan_start;
  } in_item_t;

  typedef struct packed {
    logic signed [MAP_W-1:0] map_x;
    logic signed [MAP_W-1:0] map_y;
    logic [IDX_W-1:0]        beam_index;
    logic [RNG_W-1:0]        range_out;
  } out_item_t;

  typedef struct packed {
    logic [RNG_W-1:0]        range_lo;
    logic [RNG_W-1:0]        range_hi;
    logic [ANG_W-1:0]        angle_start;
    logic [ANG_W-1:0]        angle_step;
    logic signed [MAP_W-1:0] pose_x;
    logic signed [MAP_W-1:0] pose_y;
    logic [ANG_W-1:0]        pose_heading;
    logic signed [ANG_W-1:0] laser_offset_x;
  } cfg_t;

  // One accepted beam with a valid range, as it waits between front and back.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [ANG_W-1:0] ang;
    logic [RNG_W-1:0] rng;
  } beam_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [RNG_W-1:0] rng;
  } meta_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] ang;
    logic                    flip;
  } red_ang_t;

  // Folds an angle into [-quarter, +quarter] turn; flip asks for a negated vector.
  function automatic red_ang_t reduce_angle(logic [ANG_W-1:0] a);
    logic signed [ANG_W:0] s;
    red_ang_t res;
    s = {a[ANG_W-1], a};
    res.flip = 1'b0;
    res.ang = a;
    if (s > QUARTER_POS) begin
      res.ang = ANG_W'(s - HALF_TURN);
      res.flip = 1'b1;
    end else if (s < QUARTER_NEG) begin
      res.ang = ANG_W'(s + HALF_TURN);
      res.flip = 1'b1;
    end
    return res;
  endfunction

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(int unsigned i);
    logic [31:0] v;
    case (i)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/lsmp_cfg.sv =====
// Configuration register file with an APB-style access port.
// Depends on lsmp_pkg for the register codes and the cfg_t bundle.
module lsmp_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsmp_pkg::ADDR_W-1:0]  paddr,
  input  logic [lsmp_pkg::DATA_W-1:0]  pwdata,
  output logic [lsmp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output lsmp_pkg::cfg_t               cfg
);

  lsmp_pkg::cfg_t     cfg_r;
  lsmp_pkg::reg_idx_t sel;
  logic               wr_en;

  assign pready = 1'b1;
  assign sel    = lsmp_pkg::reg_idx_t'(paddr[lsmp_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_lo       <= '0;
      cfg_r.range_hi       <= '1;
      cfg_r.angle_start    <= '0;
      cfg_r.angle_step     <= '0;
      cfg_r.pose_x         <= '0;
      cfg_r.pose_y         <= '0;
      cfg_r.pose_heading   <= '0;
      cfg_r.laser_offset_x <= '0;
    end else if (wr_en) begin
      case (sel)
        lsmp_pkg::REG_RANGE_MIN:    cfg_r.range_lo <= pwdata[lsmp_pkg::RNG_W-1:0];
        lsmp_pkg::REG_RANGE_MAX:    cfg_r.range_hi <= pwdata[lsmp_pkg::RNG_W-1:0];
        lsmp_pkg::REG_ANGLE_START:  cfg_r.angle_start <= pwdata[lsmp_pkg::ANG_W-1:0];
        lsmp_pkg::REG_ANGLE_STEP:   cfg_r.angle_step <= pwdata[lsmp_pkg::ANG_W-1:0];
        lsmp_pkg::REG_POSE_X:       cfg_r.pose_x <= pwdata[lsmp_pkg::MAP_W-1:0];
        lsmp_pkg::REG_POSE_Y:       cfg_r.pose_y <= pwdata[lsmp_pkg::MAP_W-1:0];
        lsmp_pkg::REG_POSE_HEADING: cfg_r.pose_heading <= pwdata[lsmp_pkg::ANG_W-1:0];
        lsmp_pkg::REG_LASER_OFS_X:  cfg_r.laser_offset_x <= pwdata[lsmp_pkg::ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      lsmp_pkg::REG_RANGE_MIN:    prdata = lsmp_pkg::DATA_W'(cfg_r.range_lo);
      lsmp_pkg::REG_RANGE_MAX:    prdata = lsmp_pkg::DATA_W'(cfg_r.range_hi);
      lsmp_pkg::REG_ANGLE_START:  prdata = lsmp_pkg::DATA_W'(cfg_r.angle_start);
      lsmp_pkg::REG_ANGLE_STEP:   prdata = lsmp_pkg::DATA_W'(cfg_r.angle_step);
      lsmp_pkg::REG_POSE_X:       prdata = lsmp_pkg::DATA_W'(unsigned'(cfg_r.pose_x));
      lsmp_pkg::REG_POSE_Y:       prdata = lsmp_pkg::DATA_W'(unsigned'(cfg_r.pose_y));
      lsmp_pkg::REG_POSE_HEADING: prdata = lsmp_pkg::DATA_W'(cfg_r.pose_heading);
      lsmp_pkg::REG_LASER_OFS_X:  prdata = lsmp_pkg::DATA_W'(unsigned'(cfg_r.laser_offset_x));
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== src/lsmp_fifo.sv =====
// Small synchronous queue built from registers, used between front and back
// and in front of the result port. Depends on nothing.
module lsmp_fifo #(
  parameter int unsigned WIDTH = 44,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/lsmp_front.sv =====
// Front end: accepts beams, tracks beam index and beam angle, and forwards
// only beams whose range lies inside the window. Depends on lsmp_pkg.
module lsmp_front #(
  parameter logic [11:0] BEAM_LIMIT = 12'd4095
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lsmp_pkg::cfg_t      cfg,
  input  logic                push,
  input  lsmp_pkg::in_item_t  in_item,
  output logic                full,
  output logic                q_push,
  output lsmp_pkg::beam_t     q_data,
  input  logic                q_full
);

  logic [lsmp_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic [lsmp_pkg::ANG_W-1:0] ang_r, ang_nxt;
  logic [lsmp_pkg::IDX_W-1:0] idx;
  logic [lsmp_pkg::ANG_W-1:0] ang;
  logic                       accept;
  logic                       in_window;

  assign full   = q_full;
  assign accept = push & ~q_full;
  assign idx    = in_item.scan_start ? '0 : cnt_r;
  assign ang    = in_item.scan_start ? cfg.angle_start : ang_r;

  assign in_window = (in_item.range_mm > cfg.range_lo) && (in_item.range_mm < cfg.range_hi);

  assign q_push     = accept & in_window;
  assign q_data.idx = idx;
  assign q_data.ang = ang;
  assign q_data.rng = in_item.range_mm;

  // Once the index saturates, the angle freezes with it.
  always_comb begin
    cnt_nxt = cnt_r;
    ang_nxt = ang_r;
    if (accept) begin
      if (idx < BEAM_LIMIT) begin
        cnt_nxt = idx + 1'b1;
        ang_nxt = ang + cfg.angle_step;
      end else begin
        cnt_nxt = idx;
        ang_nxt = ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ang_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      ang_r <= ang_nxt;
    end
  end

endmodule

// ===== src/lsmp_back.sv =====
// Back end: a stallable pipeline that folds the angles, scales by the CORDIC
// gain, runs two rotation-mode CORDIC lanes (beam and mount offset) one stage
// per clock, then rounds, adds the pose and saturates. Depends on lsmp_pkg.
module lsmp_back #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lsmp_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  lsmp_pkg::beam_t     q_data,
  output logic                q_pop,
  output logic                o_push,
  output lsmp_pkg::out_item_t o_data,
  input  logic                o_full
);

  localparam int unsigned N  = CORDIC_STAGES;
  localparam int unsigned L  = N + 3;
  localparam int unsigned XW = lsmp_pkg::XW;
  localparam int unsigned ZW = lsmp_pkg::ZW;
  localparam int unsigned VW = lsmp_pkg::VEC_W;
  localparam int unsigned PW = lsmp_pkg::PROD_W;
  localparam int unsigned SW = lsmp_pkg::SUM_W;
  localparam int unsigned RW = lsmp_pkg::RND_W;
  localparam int unsigned AW = lsmp_pkg::ANG_W;

  logic                    adv;
  logic [L-1:0]            vld_r;
  lsmp_pkg::meta_t         meta_r [L];

  // Stage A: folded angles and signed start magnitudes.
  lsmp_pkg::red_ang_t      red_b, red_o;
  logic [AW-1:0]           beam_ang;
  logic signed [VW-1:0]    vb_nxt, vo_nxt, vb_r, vo_r;
  logic signed [AW-1:0]    ab_r, ao_r;

  // Stage B feeds the CORDIC arrays at index 0.
  logic signed [PW-1:0]    pb, po;
  logic signed [XW-1:0]    xb_r [N+1];
  logic signed [XW-1:0]    yb_r [N+1];
  logic signed [ZW-1:0]    zb_r [N+1];
  logic signed [XW-1:0]    xo_r [N+1];
  logic signed [XW-1:0]    yo_r [N+1];
  logic signed [ZW-1:0]    zo_r [N+1];

  // Final stage.
  logic signed [RW-1:0]    rbx, rby, rox, roy;
  logic signed [SW-1:0]    sum_x, sum_y;
  logic signed [lsmp_pkg::MAP_W-1:0] map_x_nxt, map_y_nxt, map_x_r, map_y_r;

  assign adv    = ~o_full;
  assign q_pop  = adv & ~q_empty;
  assign o_push = vld_r[L-1] & adv;

  assign beam_ang = q_data.ang + cfg.pose_heading;
  assign red_b    = lsmp_pkg::reduce_angle(beam_ang);
  assign red_o    = lsmp_pkg::reduce_angle(cfg.pose_heading);

  always_comb begin
    vb_nxt = red_b.flip ? -VW'(q_data.rng) : VW'(q_data.rng);
    vo_nxt = red_o.flip ? -VW'(cfg.laser_offset_x) : VW'(cfg.laser_offset_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0].idx <= q_data.idx;
      meta_r[0].rng <= q_data.rng;
      for (int j = 1; j < L; j++) begin
        meta_r[j] <= meta_r[j-1];
      end
      vb_r <= vb_nxt;
      vo_r <= vo_nxt;
      ab_r <= red_b.ang;
      ao_r <= red_o.ang;
    end
  end

  // Start vector (v*K, 0) in Q16; angle moves to 2^-32 turn units.
  assign pb = vb_r * $signed({1'b0, lsmp_pkg::CORDIC_GAIN});
  assign po = vo_r * $signed({1'b0, lsmp_pkg::CORDIC_GAIN});

  always_ff @(posedge clk) begin
    if (adv) begin
      xb_r[0] <= XW'(pb >>> lsmp_pkg::GAIN_SHIFT);
      yb_r[0] <= '0;
      zb_r[0] <= {ab_r[AW-1], ab_r, 16'h0000};
      xo_r[0] <= XW'(po >>> lsmp_pkg::GAIN_SHIFT);
      yo_r[0] <= '0;
      zo_r[0] <= {ao_r[AW-1], ao_r, 16'h0000};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = ZW'(lsmp_pkg::atan_turn(k));
    logic signed [XW-1:0] xb_nxt, yb_nxt, xo_nxt, yo_nxt;
    logic signed [ZW-1:0] zb_nxt, zo_nxt;

    always_comb begin
      if (!zb_r[k][ZW-1]) begin
        xb_nxt = xb_r[k] - (yb_r[k] >>> k);
        yb_nxt = yb_r[k] + (xb_r[k] >>> k);
        zb_nxt = zb_r[k] - ATAN;
      end else begin
        xb_nxt = xb_r[k] + (yb_r[k] >>> k);
        yb_nxt = yb_r[k] - (xb_r[k] >>> k);
        zb_nxt = zb_r[k] + ATAN;
      end
      if (!zo_r[k][ZW-1]) begin
        xo_nxt = xo_r[k] - (yo_r[k] >>> k);
        yo_nxt = yo_r[k] + (xo_r[k] >>> k);
        zo_nxt = zo_r[k] - ATAN;
      end else begin
        xo_nxt = xo_r[k] + (yo_r[k] >>> k);
        yo_nxt = yo_r[k] - (xo_r[k] >>> k);
        zo_nxt = zo_r[k] + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        xb_r[k+1] <= xb_nxt;
        yb_r[k+1] <= yb_nxt;
        zb_r[k+1] <= zb_nxt;
        xo_r[k+1] <= xo_nxt;
        yo_r[k+1] <= yo_nxt;
        zo_r[k+1] <= zo_nxt;
      end
    end
  end

  // Round Q16 to millimetres, add the pose and clamp to the map range.
  always_comb begin
    rbx = RW'((xb_r[N] + lsmp_pkg::ROUND_HALF) >>> lsmp_pkg::FRAC_W);
    rby = RW'((yb_r[N] + lsmp_pkg::ROUND_HALF) >>> lsmp_pkg::FRAC_W);
    rox = RW'((xo_r[N] + lsmp_pkg::ROUND_HALF) >>> lsmp_pkg::FRAC_W);
    roy = RW'((yo_r[N] + lsmp_pkg::ROUND_HALF) >>> lsmp_pkg::FRAC_W);
    sum_x = SW'(cfg.pose_x) + SW'(rox) + SW'(rbx);
    sum_y = SW'(cfg.pose_y) + SW'(roy) + SW'(rby);
    if (sum_x > lsmp_pkg::MAP_MAX) begin
      map_x_nxt = lsmp_pkg::MAP_W'(lsmp_pkg::MAP_MAX);
    end else if (sum_x < lsmp_pkg::MAP_MIN) begin
      map_x_nxt = lsmp_pkg::MAP_W'(lsmp_pkg::MAP_MIN);
    end else begin
      map_x_nxt = lsmp_pkg::MAP_W'(sum_x);
    end
    if (sum_y > lsmp_pkg::MAP_MAX) begin
      map_y_nxt = lsmp_pkg::MAP_W'(lsmp_pkg::MAP_MAX);
    end else if (sum_y < lsmp_pkg::MAP_MIN) begin
      map_y_nxt = lsmp_pkg::MAP_W'(lsmp_pkg::MAP_MIN);
    end else begin
      map_y_nxt = lsmp_pkg::MAP_W'(sum_y);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      map_x_r <= map_x_nxt;
      map_y_r <= map_y_nxt;
    end
  end

  assign o_data.map_x      = map_x_r;
  assign o_data.map_y      = map_y_r;
  assign o_data.beam_index = meta_r[L-1].idx;
  assign o_data.range_out  = meta_r[L-1].rng;

endmodule

// ===== src/lidar_scan_to_map_points.sv =====
// Top level of the lidar scan-to-map point converter.
// Depends on lsmp_pkg, lsmp_cfg, lsmp_front, lsmp_fifo and lsmp_back.

// One beam can be pushed every clock cycle while full is low, and one map point
// popped every cycle while empty is low; beams whose range falls outside the open
// window between the minimum and maximum range produce no point but still advance
// the beam index and angle. A point reaches the result queue through the
// pipelined CORDIC, one stage per cycle while it does not stall. full is
// raised only when the four-entry queue between the front end and the
// CORDIC pipeline fills, which happens when the pipeline stalls because the
// two-entry result queue is not being drained.
module lidar_scan_to_map_points #(
  parameter int unsigned MAX_BEAMS     = 4096,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  lsmp_pkg::in_item_t          in_item,
  output logic                        empty,
  input  logic                        pop,
  output lsmp_pkg::out_item_t         out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsmp_pkg::ADDR_W-1:0] paddr,
  input  logic [lsmp_pkg::DATA_W-1:0] pwdata,
  output logic [lsmp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned LIMIT_I =
    (MAX_BEAMS - 1 < lsmp_pkg::IDX_CAP) ? MAX_BEAMS - 1 : lsmp_pkg::IDX_CAP;
  localparam logic [lsmp_pkg::IDX_W-1:0] BEAM_LIMIT = lsmp_pkg::IDX_W'(LIMIT_I);
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 2;

  lsmp_pkg::cfg_t      cfg;
  lsmp_pkg::beam_t     fq_data, bq_data;
  lsmp_pkg::out_item_t bo_data;
  logic                fq_push, fq_full, bq_empty, bq_pop;
  logic                bo_push, bo_full;

  lsmp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsmp_front #(
    .BEAM_LIMIT (BEAM_LIMIT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_push  (fq_push),
    .q_data  (fq_data),
    .q_full  (fq_full)
  );

  lsmp_fifo #(
    .WIDTH ($bits(lsmp_pkg::beam_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_data),
    .full    (fq_full),
    .rd_en   (bq_pop),
    .rd_data (bq_data),
    .empty   (bq_empty)
  );

  lsmp_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (bq_empty),
    .q_data  (bq_data),
    .q_pop   (bq_pop),
    .o_push  (bo_push),
    .o_data  (bo_data),
    .o_full  (bo_full)
  );

  lsmp_fifo #(
    .WIDTH ($bits(lsmp_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bo_push),
    .wr_data (bo_data),
    .full    (bo_full),
    .rd_en   (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

endmodule

// ===== src/lsmp_checker.sv =====
// Port-level checks for the lidar scan-to-map point converter, bound to the
// top level. Depends on lsmp_pkg and lidar_scan_to_map_points.
module lsmp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input lsmp_pkg::out_item_t         out_item,
  input logic                        pready
);

  // Reset leaves both queues empty, so nothing is shown and input is open.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not clear after reset");

  // A zero range can never pass the window, so it must never come out.
  a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_item.range_out != '0)
    else $error("result with zero range");

  // The input side can only fill up after a transaction was taken on it.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed or vanished");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port inserted wait states");

endmodule

bind lidar_scan_to_map_points lsmp_checker u_lsmp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item),
  .pready   (pready)
);

// ===== bench/lidar_scan_to_map_points_tb.sv =====
// Self-checking testbench for lidar_scan_to_map_points: beams in, map points out,
// checked against a CORDIC scoreboard model held in this file.
// Depends on lsmp_pkg and the RTL in src.
module lidar_scan_to_map_points_tb;

  localparam int unsigned MAX_BEAMS     = 4096;
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int          BEAM_CAP      = (MAX_BEAMS - 1 < 4095) ? MAX_BEAMS - 1 : 4095;
  localparam int          SETTLE_CYC    = CORDIC_STAGES + 16;
  localparam int          LIMIT_CYC     = 1_000_000;
  localparam longint      GAIN_Q30      = 64'sd652032874;
  localparam longint      ATAN_TAB [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_IDX} row_chk_t;
  typedef enum logic {ROW_BEAM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    lsmp_pkg::reg_idx_t addr;
    logic [31:0]        value;
    lsmp_pkg::in_item_t beam;
    row_chk_t           chk;
    logic [11:0]        idx;
  } dir_row_t;

  logic                          clk;
  logic                          rst_n   = 1'b0;
  logic                          push    = 1'b0;
  logic                          full;
  lsmp_pkg::in_item_t            in_item = '0;
  logic                          empty;
  logic                          pop     = 1'b0;
  lsmp_pkg::out_item_t           out_item;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [lsmp_pkg::ADDR_W-1:0]   paddr   = '0;
  logic [lsmp_pkg::DATA_W-1:0]   pwdata  = '0;
  logic [lsmp_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // Scoreboard state: register shadow, beam counter and angle, pending points.
  lsmp_pkg::cfg_t                regs;
  logic [lsmp_pkg::IDX_W-1:0]    beam_cnt = '0;
  logic [lsmp_pkg::ANG_W-1:0]    beam_ang = '0;
  lsmp_pkg::out_item_t           exp_points [$];
  int                            fail_count = 0;
  int                            cycles = 0;
  bit                            tx_fast = 1'b0;
  bit                            rx_fast = 1'b0;

  lidar_scan_to_map_points #(
    .MAX_BEAMS     (MAX_BEAMS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYC) begin
      $display("timeout after %0d cycles, %0d points pending", cycles, exp_points.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Rotation-mode CORDIC of the vector (vec, 0); results rounded to whole millimetres.
  function automatic void cordic_rotate(input longint vec, input logic [15:0] ang,
                                        output longint cx, output longint cy);
    longint a, x, y, z, nx;
    a = longint'($signed(ang));
    // Fold into the right half plane; the vector is negated to compensate.
    if (a > 16384) begin
      a = a - 32768;
      vec = -vec;
    end else if (a < -16384) begin
      a = a + 32768;
      vec = -vec;
    end
    x = (vec * GAIN_Q30) >>> 14;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TAB[i];
      end
      x = nx;
    end
    cx = (x + 32768) >>> 16;
    cy = (y + 32768) >>> 16;
  endfunction

  function automatic logic [lsmp_pkg::MAP_W-1:0] clamp_map(longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[lsmp_pkg::MAP_W-1:0];
  endfunction

  // Advances the beam counter and angle; returns 1 with the point if the range is valid.
  function automatic bit predict_point(input lsmp_pkg::in_item_t beam,
                                       output lsmp_pkg::out_item_t pt);
    logic [lsmp_pkg::IDX_W-1:0] idx;
    logic [lsmp_pkg::ANG_W-1:0] ang;
    longint ox, oy, bx, by;
    idx = beam.scan_start ? '0 : beam_cnt;
    ang = beam.scan_start ? regs.angle_start : beam_ang;
    if (idx < BEAM_CAP) begin
      beam_cnt = idx + 1'b1;
      beam_ang = ang + regs.angle_step;
    end else begin
      beam_cnt = idx;
      beam_ang = ang;
    end
    pt = '0;
    if (beam.range_mm <= regs.range_lo || beam.range_mm >= regs.range_hi) return 1'b0;
    cordic_rotate(longint'($signed(regs.laser_offset_x)), regs.pose_heading, ox, oy);
    cordic_rotate(longint'(beam.range_mm), ang + regs.pose_heading, bx, by);
    pt.map_x      = clamp_map(longint'($signed(regs.pose_x)) + ox + bx);
    pt.map_y      = clamp_map(longint'($signed(regs.pose_y)) + oy + by);
    pt.beam_index = idx;
    pt.range_out  = beam.range_mm;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    fail_count++;
    $display("[%0d] mismatch on %s: got %0d, expected %0d", cycles, what, got, want);
  endtask

  task automatic check_point(lsmp_pkg::out_item_t got);
    lsmp_pkg::out_item_t want;
    if (exp_points.size() == 0) begin
      flag_mismatch("point with no beam pending", int'(got.beam_index), -1);
      return;
    end
    want = exp_points.pop_front();
    if (got.map_x !== want.map_x)
      flag_mismatch("map_x", int'($signed(got.map_x)), int'($signed(want.map_x)));
    if (got.map_y !== want.map_y)
      flag_mismatch("map_y", int'($signed(got.map_y)), int'($signed(want.map_y)));
    if (got.beam_index !== want.beam_index)
      flag_mismatch("beam_index", int'(got.beam_index), int'(want.beam_index));
    if (got.range_out !== want.range_out)
      flag_mismatch("range_out", int'(got.range_out), int'(want.range_out));
  endtask

  // Sends one beam; the transaction completes when push is high and full is low.
  task automatic send_beam(lsmp_pkg::in_item_t beam, row_chk_t chk, logic [11:0] idx);
    int                  gap;
    bit                  acc;
    bit                  valid;
    lsmp_pkg::out_item_t pt;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= beam;
    do begin
      @(negedge clk);
      acc = !full;
      @(posedge clk);
    end while (!acc);
    valid = predict_point(beam, pt);
    case (chk)
      CHK_NONE: ;
      CHK_IDX: begin
        pt.beam_index = idx;
        pt.range_out  = beam.range_mm;
        exp_points = {exp_points, pt};
      end
      default: if (valid) exp_points = {exp_points, pt};
    endcase
  endtask

  task automatic drain_points();
    push <= 1'b0;
    @(posedge clk);
    while (exp_points.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic settle_block();
    drain_points();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(lsmp_pkg::reg_idx_t r, logic [31:0] v);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lsmp_pkg::ADDR_W'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (r)
      lsmp_pkg::REG_RANGE_MIN:    regs.range_lo       = v[15:0];
      lsmp_pkg::REG_RANGE_MAX:    regs.range_hi       = v[15:0];
      lsmp_pkg::REG_ANGLE_START:  regs.angle_start    = v[15:0];
      lsmp_pkg::REG_ANGLE_STEP:   regs.angle_step     = v[15:0];
      lsmp_pkg::REG_POSE_X:       regs.pose_x         = v[23:0];
      lsmp_pkg::REG_POSE_Y:       regs.pose_y         = v[23:0];
      lsmp_pkg::REG_POSE_HEADING: regs.pose_heading   = v[15:0];
      default:                    regs.laser_offset_x = v[15:0];
    endcase
  endtask

  function automatic dir_row_t beam_row(logic [15:0] r, logic s, row_chk_t c, logic [11:0] idx);
    dir_row_t row;
    row.kind            = ROW_BEAM;
    row.addr            = lsmp_pkg::REG_RANGE_MIN;
    row.value           = '0;
    row.beam.range_mm   = r;
    row.beam.scan_start = s;
    row.chk             = c;
    row.idx             = idx;
    return row;
  endfunction

  function automatic dir_row_t reg_row(lsmp_pkg::reg_idx_t a, logic [31:0] v);
    dir_row_t row;
    row       = beam_row('0, 1'b0, CHK_NONE, '0);
    row.kind  = ROW_REG;
    row.addr  = a;
    row.value = v;
    return row;
  endfunction

  function automatic logic [31:0] pick_pose();
    int t;
    t = $urandom_range(0, 200000) - 100000;
    if ($urandom_range(0, 1) == 0) return $urandom() & 32'hFF_FFFF;
    return 32'(t);
  endfunction

  task automatic random_setup();
    int lo, hi;
    case ($urandom_range(0, 3))
      0:       lo = 0;
      1:       lo = $urandom_range(0, 3000);
      2:       lo = $urandom_range(0, 65535);
      default: lo = $urandom_range(0, 200);
    endcase
    case ($urandom_range(0, 3))
      0:       hi = 65535;
      1:       hi = $urandom_range(30000, 65535);
      2:       hi = $urandom_range(0, 65535);
      default: hi = (lo + $urandom_range(2, 400) > 65535) ? 65535 : lo + $urandom_range(2, 400);
    endcase
    settle_block();
    write_reg(lsmp_pkg::REG_RANGE_MIN, 32'(lo));
    write_reg(lsmp_pkg::REG_RANGE_MAX, 32'(hi));
    write_reg(lsmp_pkg::REG_ANGLE_START, $urandom() & 32'hFFFF);
    if ($urandom_range(0, 1) == 0)
      write_reg(lsmp_pkg::REG_ANGLE_STEP, 32'($urandom_range(0, 2047) - 1024) & 32'hFFFF);
    else
      write_reg(lsmp_pkg::REG_ANGLE_STEP, $urandom() & 32'hFFFF);
    write_reg(lsmp_pkg::REG_POSE_X, pick_pose());
    write_reg(lsmp_pkg::REG_POSE_Y, pick_pose());
    write_reg(lsmp_pkg::REG_POSE_HEADING, $urandom() & 32'hFFFF);
    write_reg(lsmp_pkg::REG_LASER_OFS_X, $urandom() & 32'hFFFF);
  endtask

  // Mostly in-window ranges, with window edges and full-scale values mixed in.
  function automatic logic [15:0] pick_range();
    int sel, lo, hi;
    lo  = regs.range_lo;
    hi  = regs.range_hi;
    sel = $urandom_range(0, 19);
    if (sel < 14 && lo + 1 < hi) return 16'($urandom_range(lo + 1, hi - 1));
    case (sel)
      17:      return regs.range_lo;
      18:      return regs.range_hi;
      19:      return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic run_scans(int n);
    int                 sent, len;
    lsmp_pkg::in_item_t b;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 60);
      if ($urandom_range(0, 5) == 0) tx_fast = !tx_fast;
      for (int k = 0; k < len && sent < n; k++) begin
        // Occasionally a scan has no start flag, or gets one midway.
        b.scan_start = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 59) == 0);
        b.range_mm   = pick_range();
        send_beam(b, CHK_MODEL, '0);
        sent++;
      end
    end
  endtask

  initial begin : result_sink
    int                  stall;
    bit                  acc;
    lsmp_pkg::out_item_t got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk);
        acc = !empty;
        got = out_item;
        @(posedge clk);
      end while (!acc);
      check_point(got);
      if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows [$];
    regs             = '0;
    regs.range_hi    = 16'hFFFF;

    // Reset values first: beams before any scan start count from zero.
    dir_rows = {dir_rows, beam_row(16'd0,     1'b0, CHK_NONE, 12'd0)};
    dir_rows = {dir_rows, beam_row(16'd65535, 1'b0, CHK_NONE, 12'd1)};
    dir_rows = {dir_rows, beam_row(16'd1,     1'b0, CHK_IDX,  12'd2)};
    dir_rows = {dir_rows, beam_row(16'd65534, 1'b1, CHK_IDX,  12'd0)};
    dir_rows = {dir_rows, beam_row(16'd32768, 1'b0, CHK_IDX,  12'd1)};
    // Narrow window, extreme pose and angles: saturated coordinates and angle wrap.
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MIN,    32'd100)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MAX,    32'd200)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_ANGLE_START,  32'h8000)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_ANGLE_STEP,   32'h4000)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_X,       32'h7F_FFFF)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_Y,       32'h80_0000)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_HEADING, 32'h7FFF)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_LASER_OFS_X,  32'h7FFF)};
    dir_rows = {dir_rows, beam_row(16'd100, 1'b1, CHK_NONE, 12'd0)};
    dir_rows = {dir_rows, beam_row(16'd200, 1'b0, CHK_NONE, 12'd1)};
    dir_rows = {dir_rows, beam_row(16'd101, 1'b0, CHK_IDX,  12'd2)};
    dir_rows = {dir_rows, beam_row(16'd199, 1'b0, CHK_IDX,  12'd3)};
    dir_rows = {dir_rows, beam_row(16'd150, 1'b0, CHK_IDX,  12'd4)};
    // The opposite extremes.
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MIN,    32'd0)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MAX,    32'd65535)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_ANGLE_START,  32'h7FFF)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_ANGLE_STEP,   32'h7FFF)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_X,       32'h80_0000)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_Y,       32'h7F_FFFF)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_HEADING, 32'h8000)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_LASER_OFS_X,  32'h8000)};
    dir_rows = {dir_rows, beam_row(16'd65534, 1'b1, CHK_IDX,   12'd0)};
    dir_rows = {dir_rows, beam_row(16'd65534, 1'b0, CHK_IDX,   12'd1)};
    dir_rows = {dir_rows, beam_row(16'd1,     1'b0, CHK_IDX,   12'd2)};
    dir_rows = {dir_rows, beam_row(16'hAAAA,  1'b0, CHK_MODEL, 12'd0)};
    dir_rows = {dir_rows, beam_row(16'h5555,  1'b0, CHK_MODEL, 12'd0)};
    // An empty window rejects everything.
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MIN, 32'd500)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MAX, 32'd500)};
    dir_rows = {dir_rows, beam_row(16'd499, 1'b1, CHK_NONE, 12'd0)};
    dir_rows = {dir_rows, beam_row(16'd500, 1'b0, CHK_NONE, 12'd1)};
    dir_rows = {dir_rows, beam_row(16'd501, 1'b0, CHK_NONE, 12'd2)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MIN, 32'd65535)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MAX, 32'd0)};
    dir_rows = {dir_rows, beam_row(16'd0,     1'b1, CHK_NONE, 12'd0)};
    dir_rows = {dir_rows, beam_row(16'd65535, 1'b0, CHK_NONE, 12'd1)};
    dir_rows = {dir_rows, beam_row(16'd32768, 1'b0, CHK_NONE, 12'd2)};
    // Quarter-turn headings sit on the fold boundary of the rotator.
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MIN,    32'd0)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_RANGE_MAX,    32'd65535)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_ANGLE_START,  32'd0)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_ANGLE_STEP,   32'd0)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_X,       32'd0)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_Y,       32'd0)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_LASER_OFS_X,  32'd1000)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_HEADING, 32'h4000)};
    dir_rows = {dir_rows, beam_row(16'd1000, 1'b1, CHK_MODEL, 12'd0)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_HEADING, 32'hC000)};
    dir_rows = {dir_rows, beam_row(16'd1000, 1'b0, CHK_MODEL, 12'd0)};
    dir_rows = {dir_rows, reg_row(lsmp_pkg::REG_POSE_HEADING, 32'h4001)};
    dir_rows = {dir_rows, beam_row(16'd777,  1'b0, CHK_MODEL, 12'd0)};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        settle_block();
        write_reg(dir_rows[i].addr, dir_rows[i].value);
      end else begin
        send_beam(dir_rows[i].beam, dir_rows[i].chk, dir_rows[i].idx);
      end
    end

    for (int p = 0; p < 6; p++) begin
      random_setup();
      if (p == 3) begin
        run_scans(100);
        // Hold the sender off until every pending point has come back.
        drain_points();
        run_scans(110);
      end else begin
        run_scans(210);
      end
    end

    drain_points();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
